// ----- hdl/xosj_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// xosj_pkg
// Shared types, constants and step functions of the xoshiro256** generator.
// ----------------------------------------------------------------------------
package xosj_pkg;

  // Command codes carried by an input beat.
  localparam logic [1:0] CMD_NEXT   = 2'd0;
  localparam logic [1:0] CMD_JUMP   = 2'd1;
  localparam logic [1:0] CMD_RESEED = 2'd2;

  localparam logic [63:0] GOLDEN_STEP = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX_MUL_A   = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_MUL_B   = 64'h94d049bb133111eb;

  // Jump polynomial, bit n of the 256-bit word is bit n of the polynomial.
  localparam logic [255:0] JUMP_POLY = {
    64'h39abdc4529b1661c, 64'ha9582618e03fc9aa,
    64'hd5a61266f0c9392c, 64'h180ec6d33cfd0aba
  };

  typedef logic [3:0][63:0] words_t;

  typedef enum logic [3:0] {
    DP_HOLD,
    DP_NEXT,
    DP_LOAD,
    DP_MIXADD,
    DP_MUL0,
    DP_MUL1,
    DP_MUL2,
    DP_XOR27,
    DP_STORE,
    DP_JSTEP,
    DP_JFIN
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   mul_b;   // Multiply by the second splitmix constant.
  } dp_cmd_t;

  typedef struct packed {
    logic jump_last;  // The jump is at its last polynomial bit.
    logic seed_last;  // The reseed is filling the last state word.
  } dp_status_t;

  // One xoshiro256 state transition.
  function automatic words_t gen_step(input words_t s);
    words_t      n;
    logic [63:0] t;
    t    = s[1] << 17;
    n    = s;
    n[2] = s[2] ^ s[0];
    n[3] = s[3] ^ s[1];
    n[1] = s[1] ^ n[2];
    n[0] = s[0] ^ n[3];
    n[2] = n[2] ^ t;
    n[3] = {n[3][18:0], n[3][63:19]};
    return n;
  endfunction

  // The ** scrambler: rotl(s1 * 5, 7) * 9, built from shifts and adds.
  function automatic logic [63:0] gen_star(input logic [63:0] s1);
    logic [63:0] m5;
    logic [63:0] r;
    m5 = s1 + (s1 << 2);
    r  = {m5[56:0], m5[63:57]};
    return r + (r << 3);
  endfunction

endpackage
`default_nettype wire

// ----- hdl/xosj_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// xosj_datapath
// Generator state, splitmix64 unit with a shared 32x32 multiplier, jump
// accumulator and the output word register.
// ----------------------------------------------------------------------------
module xosj_datapath
  import xosj_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire dp_cmd_t     cmd,
  input  wire logic [63:0] seed,
  output dp_status_t       status,
  output logic [63:0]      random_value,
  output logic [52:0]      unit_fraction
);

  words_t      words_r, words_nxt;
  words_t      jacc_r, jacc_nxt;
  logic [63:0] cnt_r, cnt_nxt;
  logic [63:0] z_r, z_nxt;
  logic [63:0] prod_r, prod_nxt;
  logic [63:0] rand_r, rand_nxt;
  logic [7:0]  idx_r, idx_nxt;
  logic [1:0]  widx_r, widx_nxt;

  logic [63:0] kconst;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [63:0] cnt_add;

  assign kconst  = cmd.mul_b ? MIX_MUL_B : MIX_MUL_A;
  assign cnt_add = cnt_r + GOLDEN_STEP;

  // Low 64 bits of a 64x64 product in three 32x32 partial products.
  always_comb begin
    mul_a = z_r[31:0];
    mul_b = kconst[31:0];
    if (cmd.op == DP_MUL1) begin
      mul_b = kconst[63:32];
    end else if (cmd.op == DP_MUL2) begin
      mul_a = z_r[63:32];
    end
  end
  assign mul_p = mul_a * mul_b;

  always_comb begin
    words_nxt = words_r;
    jacc_nxt  = jacc_r;
    cnt_nxt   = cnt_r;
    z_nxt     = z_r;
    prod_nxt  = prod_r;
    rand_nxt  = rand_r;
    idx_nxt   = idx_r;
    widx_nxt  = widx_r;
    unique case (cmd.op)
      DP_HOLD: begin
      end
      DP_NEXT: begin
        rand_nxt  = gen_star(words_r[1]);
        words_nxt = gen_step(words_r);
      end
      DP_LOAD: begin
        cnt_nxt  = seed;
        widx_nxt = 2'd0;
      end
      DP_MIXADD: begin
        cnt_nxt = cnt_add;
        z_nxt   = cnt_add ^ (cnt_add >> 30);
      end
      DP_MUL0: begin
        prod_nxt = mul_p;
      end
      DP_MUL1, DP_MUL2: begin
        prod_nxt[63:32] = prod_r[63:32] + mul_p[31:0];
      end
      DP_XOR27: begin
        z_nxt = prod_r ^ (prod_r >> 27);
      end
      DP_STORE: begin
        words_nxt[widx_r] = prod_r ^ (prod_r >> 31);
        widx_nxt          = widx_r + 2'd1;
      end
      DP_JSTEP: begin
        if (JUMP_POLY[idx_r]) begin
          jacc_nxt = jacc_r ^ words_r;
        end
        words_nxt = gen_step(words_r);
        idx_nxt   = idx_r + 8'd1;
      end
      DP_JFIN: begin
        words_nxt = jacc_r;
        jacc_nxt  = '0;
        idx_nxt   = 8'd0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      words_r <= '0;
      jacc_r  <= '0;
      cnt_r   <= '0;
      idx_r   <= '0;
      widx_r  <= '0;
    end else begin
      words_r <= words_nxt;
      jacc_r  <= jacc_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
      widx_r  <= widx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    z_r    <= z_nxt;
    prod_r <= prod_nxt;
    rand_r <= rand_nxt;
  end

  assign status.jump_last = (idx_r == 8'hff);
  assign status.seed_last = (widx_r == 2'd3);
  assign random_value     = rand_r;
  assign unit_fraction    = rand_r[63:11];

endmodule
`default_nettype wire

// ----- hdl/xosj_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// xosj_ctrl
// Command sequencer: input handshake, output beat register valid, and the
// reseed and jump sequences.
// ----------------------------------------------------------------------------
module xosj_ctrl
  import xosj_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] in_cmd,
  output logic            out_valid,
  input  wire logic       out_stall,
  output dp_cmd_t         dp_cmd,
  input  wire dp_status_t dp_status
);

  typedef enum logic [11:0] {
    S_IDLE = 12'b0000_0000_0001,
    S_SEED = 12'b0000_0000_0010,
    S_MA0  = 12'b0000_0000_0100,
    S_MA1  = 12'b0000_0000_1000,
    S_MA2  = 12'b0000_0001_0000,
    S_MX   = 12'b0000_0010_0000,
    S_MB0  = 12'b0000_0100_0000,
    S_MB1  = 12'b0000_1000_0000,
    S_MB2  = 12'b0001_0000_0000,
    S_MS   = 12'b0010_0000_0000,
    S_JUMP = 12'b0100_0000_0000,
    S_JFIN = 12'b1000_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;
  logic   accept;

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE) || !slot_free;
  assign accept    = in_valid && !in_stall;

  always_comb begin
    state_nxt     = state_r;
    dp_cmd.op     = DP_HOLD;
    dp_cmd.mul_b  = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_cmd == CMD_NEXT) begin
            dp_cmd.op     = DP_NEXT;
            out_valid_nxt = 1'b1;
          end else if (in_cmd == CMD_JUMP) begin
            state_nxt = S_JUMP;
          end else if (in_cmd == CMD_RESEED) begin
            dp_cmd.op = DP_LOAD;
            state_nxt = S_SEED;
          end
        end
      end
      S_SEED: begin
        dp_cmd.op = DP_MIXADD;
        state_nxt = S_MA0;
      end
      S_MA0: begin
        dp_cmd.op = DP_MUL0;
        state_nxt = S_MA1;
      end
      S_MA1: begin
        dp_cmd.op = DP_MUL1;
        state_nxt = S_MA2;
      end
      S_MA2: begin
        dp_cmd.op = DP_MUL2;
        state_nxt = S_MX;
      end
      S_MX: begin
        dp_cmd.op = DP_XOR27;
        state_nxt = S_MB0;
      end
      S_MB0: begin
        dp_cmd.op    = DP_MUL0;
        dp_cmd.mul_b = 1'b1;
        state_nxt    = S_MB1;
      end
      S_MB1: begin
        dp_cmd.op    = DP_MUL1;
        dp_cmd.mul_b = 1'b1;
        state_nxt    = S_MB2;
      end
      S_MB2: begin
        dp_cmd.op    = DP_MUL2;
        dp_cmd.mul_b = 1'b1;
        state_nxt    = S_MS;
      end
      S_MS: begin
        dp_cmd.op = DP_STORE;
        state_nxt = dp_status.seed_last ? S_IDLE : S_SEED;
      end
      S_JUMP: begin
        dp_cmd.op = DP_JSTEP;
        if (dp_status.jump_last) begin
          state_nxt = S_JFIN;
        end
      end
      S_JFIN: begin
        dp_cmd.op = DP_JFIN;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // A new output beat appears only after an accepted next command.
  a_out_from_next: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(accept && in_cmd == CMD_NEXT))
    else $error("output beat without a next command");

  // A stalled output beat is never dropped.
  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r)
    else $error("stalled output beat lost");

  // The jump finishes only after its last polynomial bit.
  a_jump_end: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_JFIN |-> $past(state_r == S_JUMP && dp_status.jump_last))
    else $error("jump finished early");

  // The reseed returns to idle after storing the last state word.
  a_seed_end: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MS && dp_status.seed_last |=> state_r == S_IDLE)
    else $error("reseed did not end after the last word");

endmodule
`default_nettype wire

// ----- hdl/xoshiro256ss_prng_with_jump.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// xoshiro256ss_prng_with_jump
// xoshiro256** generator with splitmix64 reseed and a 2^128-step jump.
// ----------------------------------------------------------------------------
// Usage: each input beat carries a command in in_cmd. Next (0) returns one
// beat on the output channel with the 64-bit word and its top 53 bits, then
// steps the generator. Jump (1) advances the stream by 2^128 steps. Reseed
// (2) loads the splitmix64 counter from in_seed_value and fills the four
// state words. Command 3 is accepted and ignored. Only next gives a beat.
// A next command's beat shows on the output register in the cycle after
// its accept, so one word per cycle streams out while the receiver keeps
// out_stall low. A reseed holds the input after the accept, which loads
// the counter; for each state word it runs the splitmix64 steps: counter
// add and shift-xor, a multiply, a shift-xor, a second multiply and the
// store, each multiply as three 32x32 partial products on one shared
// multiplier. A jump holds the input for one generator step per polynomial
// bit plus the accept and the final copy.
// Reset clears the state to zero, so every word is zero until a reseed.
// When the receiver stalls, the pending beat holds and in_stall rises for
// a further command until the beat is taken.
// ----------------------------------------------------------------------------
module xoshiro256ss_prng_with_jump
  import xosj_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [63:0] in_seed_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      out_random_value,
  output logic [52:0]      out_unit_fraction
);

  // Command from the sequencer to the datapath and status back.
  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  xosj_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_cmd    (in_cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dp_cmd    (dp_cmd),
    .dp_status (dp_status)
  );

  // The datapath also holds the output beat register.
  xosj_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (dp_cmd),
    .seed          (in_seed_value),
    .status        (dp_status),
    .random_value  (out_random_value),
    .unit_fraction (out_unit_fraction)
  );

endmodule
`default_nettype wire
